[design/hduart_pkg.sv]
// Shared types and codes for the half-duplex serial engine.
package hduart_pkg;

    typedef enum logic [2:0] {
        OP_ARM_RX  = 3'd0,
        OP_SEND    = 3'd1,
        OP_BREAK   = 3'd2,
        OP_EDGE    = 3'd3,
        OP_TICK    = 3'd4
    } t_op;

    localparam logic CFG_EXPECTED = 1'b0;
    localparam logic CFG_TX_INV   = 1'b1;

    localparam logic [3:0] POS_MAX        = 4'd15;
    localparam logic [3:0] POS_STOP       = 4'd9;
    localparam logic [3:0] POS_REARM      = 4'd10;
    localparam logic [3:0] POS_FRAME_DONE = 4'd11;
    localparam logic [3:0] POS_IDLE       = 4'd12;
    localparam logic [3:0] DATA_END       = 4'd9;
    localparam logic [3:0] DATA_END_BREAK = 4'd10;
    localparam logic [7:0] COUNT_FULL     = 8'hff;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] data_byte;
        logic       last_of_string;
        logic       line_bit;
    } t_in_word;

    typedef struct packed {
        logic       tx_level;
        logic [7:0] rx_byte;
        logic [7:0] rx_index;
        logic       rx_store;
        logic [7:0] received_count;
        logic       tx_done;
        logic       bit_clock_on;
        logic       edge_watch_on;
    } t_out_word;

    typedef struct packed {
        logic [7:0] expected_bytes;
        logic       tx_inverted;
    } t_cfg;

endpackage

[design/hduart_core.sv]
// Line engine state and the per-word step logic.
module hduart_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  hduart_pkg::t_in_word  i_word,
    input  hduart_pkg::t_cfg      i_cfg,
    output hduart_pkg::t_out_word o_result
);
    import hduart_pkg::*;

    logic [3:0] r_pos,   n_pos;
    logic [7:0] r_shift, n_shift;
    logic [7:0] r_count, n_count;
    logic       r_idle,  n_idle;
    logic       r_send,  n_send;
    logic       r_brk,   n_brk;
    logic       r_clk_en, n_clk_en;
    logic       r_edge_en, n_edge_en;
    logic       r_last,  n_last;

    logic [3:0] pos_adv;
    logic [3:0] data_end;
    logic       tx_level;
    logic       rx_store;
    logic [7:0] rx_byte;
    logic [7:0] rx_index;

    assign pos_adv  = (r_pos == POS_MAX) ? POS_MAX : r_pos + 4'd1;
    assign data_end = r_brk ? DATA_END_BREAK : DATA_END;

    always_comb begin
        n_pos     = r_pos;
        n_shift   = r_shift;
        n_count   = r_count;
        n_idle    = r_idle;
        n_send    = r_send;
        n_brk     = r_brk;
        n_clk_en  = r_clk_en;
        n_edge_en = r_edge_en;
        n_last    = r_last;
        tx_level  = 1'b0;
        rx_store  = 1'b0;
        rx_byte   = 8'd0;
        rx_index  = 8'd0;
        unique case (i_word.op)
            OP_ARM_RX: begin
                n_count   = 8'd0;
                n_edge_en = 1'b1;
            end
            OP_SEND, OP_BREAK: begin
                n_send    = 1'b1;
                n_edge_en = 1'b0;
                n_pos     = 4'd0;
                n_clk_en  = 1'b1;
                if (i_word.op == OP_BREAK) begin
                    n_shift = 8'd0;
                    n_brk   = 1'b1;
                    n_last  = 1'b1;
                end else begin
                    n_shift = i_word.data_byte;
                    n_brk   = 1'b0;
                    n_last  = i_word.last_of_string;
                end
            end
            OP_EDGE: begin
                if (r_edge_en) begin
                    n_pos     = 4'd0;
                    n_clk_en  = 1'b1;
                    n_edge_en = 1'b0;
                    n_idle    = 1'b0;
                    n_send    = 1'b0;
                end
            end
            OP_TICK: begin
                if (r_clk_en) begin
                    n_pos = pos_adv;
                    if (r_send) begin
                        // start bit, data LSB first, then stop level
                        tx_level = ~i_cfg.tx_inverted;
                        if (r_pos == 4'd0) begin
                            tx_level = i_cfg.tx_inverted;
                        end else if (r_pos < data_end) begin
                            tx_level = i_cfg.tx_inverted ^ r_shift[0];
                            n_shift  = {1'b0, r_shift[7:1]};
                        end
                        if (pos_adv == POS_FRAME_DONE && r_last) begin
                            n_clk_en = 1'b0;
                        end
                    end else begin
                        if (r_pos == 4'd0) begin
                            // spurious start bit: drop the frame, watch again
                            if (i_word.line_bit) begin
                                n_clk_en  = 1'b0;
                                n_edge_en = 1'b1;
                            end
                            n_shift = 8'd0;
                        end else if (r_pos < POS_STOP) begin
                            n_shift = {i_word.line_bit, r_shift[7:1]};
                        end else if (r_pos == POS_STOP) begin
                            if (r_shift == 8'd0 && !i_word.line_bit) begin
                                n_count = 8'd0;
                            end else if (r_count != COUNT_FULL) begin
                                if (r_count < i_cfg.expected_bytes) begin
                                    rx_store = 1'b1;
                                    rx_byte  = r_shift;
                                    rx_index = r_count;
                                end
                                n_count = r_count + 8'd1;
                            end
                        end else if (r_pos == POS_REARM) begin
                            n_edge_en = 1'b1;
                        end else if (r_pos == POS_IDLE) begin
                            n_clk_en = 1'b0;
                            n_idle   = 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_result.tx_level       = tx_level;
        o_result.rx_byte        = rx_byte;
        o_result.rx_index       = rx_index;
        o_result.rx_store       = rx_store;
        o_result.received_count = n_idle ? n_count : 8'd0;
        o_result.tx_done        = n_send && (n_pos >= POS_FRAME_DONE);
        o_result.bit_clock_on   = n_clk_en;
        o_result.edge_watch_on  = n_edge_en;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= 4'd0;
            r_shift   <= 8'd0;
            r_count   <= 8'd0;
            r_idle    <= 1'b0;
            r_send    <= 1'b0;
            r_brk     <= 1'b0;
            r_clk_en  <= 1'b0;
            r_edge_en <= 1'b0;
            r_last    <= 1'b0;
        end else if (i_step) begin
            r_pos     <= n_pos;
            r_shift   <= n_shift;
            r_count   <= n_count;
            r_idle    <= n_idle;
            r_send    <= n_send;
            r_brk     <= n_brk;
            r_clk_en  <= n_clk_en;
            r_edge_en <= n_edge_en;
            r_last    <= n_last;
        end
    end

endmodule

[design/half_duplex_soft_uart_with_break.sv]
// An accepted word is held in the input register; its result word is registered
// in the result register. Throughput: one word per cycle while the result side is
// not stalled; both advance together, so stalls back up one stage at a time.
// Reset (synchronous, active low) clears the line engine state and both pipeline
// valids, and loads expected_bytes = 0 and tx_inverted = 1.
module half_duplex_soft_uart_with_break (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  hduart_pkg::t_in_word  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output hduart_pkg::t_out_word o_out_data,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [7:0]            i_cfg_data
);
    import hduart_pkg::*;

    t_cfg      r_cfg;
    logic      r_s1_valid;
    t_in_word  r_s1_word;
    logic      r_out_valid;
    t_out_word r_out_word;
    t_out_word result;
    logic      out_en;
    logic      step;

    assign out_en     = !r_out_valid || i_out_ready;
    assign step       = r_s1_valid && out_en;
    assign o_in_ready = !r_s1_valid || out_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.expected_bytes <= 8'd0;
            r_cfg.tx_inverted    <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_EXPECTED: r_cfg.expected_bytes <= i_cfg_data;
                CFG_TX_INV:   r_cfg.tx_inverted    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_word <= i_in_data;
        end
    end

    hduart_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_word   (r_s1_word),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_en) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_word <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_word;

`ifndef SYNTH
    // a held input word must not be lost while the result side stalls
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !out_en |=> r_s1_valid)
        else $error("input stage dropped a stalled word");

    // stored bytes come only from the receive path, with the bit clock running
    a_store_rx_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_word.rx_store |->
            !r_out_word.tx_done && r_out_word.bit_clock_on && !r_out_word.tx_level)
        else $error("byte stored outside a receive frame");

    // a result is loaded whenever the input stage hands a word over
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("result register missed a word");
`endif

endmodule
